>>> src/jsef_pkg.sv
// ----------------------------------------------------------------------------
// jsef_pkg
// Shared types and constants for the jpeg segment end finder.
// ----------------------------------------------------------------------------
package jsef_pkg;

    // byte position counter width and reported length width
    localparam int PosWidth = 32;
    localparam int LenWidth = 32;

    // marker and data byte codes
    localparam logic [7:0] BYTE_FILL    = 8'hff;
    localparam logic [7:0] BYTE_STUFF   = 8'h00;
    localparam logic [7:0] MARKER_EOI   = 8'hd9;
    localparam logic [7:0] MARKER_SOS   = 8'hda;
    localparam logic [7:0] MARKER_RST_LO = 8'hd0;
    localparam logic [7:0] MARKER_RST_HI = 8'hd7;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_FOUND  = 2'd0,
        STATUS_BROKEN = 2'd1,
        STATUS_RANOUT = 2'd2
    } status_t;

    // one decision from the segment walker
    typedef struct packed {
        logic                valid;
        status_t             status;
        logic [LenWidth-1:0] length;
    } result_t;

endpackage

>>> src/jsef_walker.sv
// ----------------------------------------------------------------------------
// jsef_walker
// Marker segment walker: holds the parse state and decides per byte.
// ----------------------------------------------------------------------------
module jsef_walker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,       // a byte is processed this cycle
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output jsef_pkg::result_t     result      // decision caused by this byte
);

    typedef enum logic [2:0] {
        PH_SKIP_START = 3'd0,
        PH_EXPECT_FF  = 3'd1,
        PH_MARKER     = 3'd2,
        PH_LEN_HI     = 3'd3,
        PH_LEN_LO     = 3'd4,
        PH_SKIP_BODY  = 3'd5,
        PH_SCAN       = 3'd6,
        PH_SCAN_FF    = 3'd7
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic                             in_scan_reg, in_scan_next;
    logic [15:0]                      seg_rem_reg, seg_rem_next;
    logic [jsef_pkg::PosWidth-1:0]    pos_reg, pos_next;
    logic                             decided_reg, decided_next;

    logic [jsef_pkg::PosWidth-1:0]    pos_inc;
    logic [15:0]                      seg_len;
    logic [15:0]                      body_rem;
    logic                             is_restart;
    logic                             has_res;
    jsef_pkg::status_t                res_status;
    logic [jsef_pkg::LenWidth-1:0]    res_length;

    assign pos_inc    = pos_reg + 1'b1;
    assign seg_len    = {seg_rem_reg[7:0], data_byte};
    assign body_rem   = (seg_rem_reg != 16'd0) ? (seg_rem_reg - 16'd1) : seg_rem_reg;
    assign is_restart = (data_byte >= jsef_pkg::MARKER_RST_LO) &&
                        (data_byte <= jsef_pkg::MARKER_RST_HI);

    // per-byte decision and next state
    always_comb
    begin
        phase_next   = phase_reg;
        in_scan_next = in_scan_reg;
        seg_rem_next = seg_rem_reg;
        pos_next     = pos_reg;
        decided_next = decided_reg;
        has_res      = 1'b0;
        res_status   = jsef_pkg::STATUS_RANOUT;
        res_length   = '0;

        if (!decided_reg)
        begin
            if (pos_reg == '1)
            begin
                // position counter exhausted
                has_res    = 1'b1;
                res_status = jsef_pkg::STATUS_RANOUT;
            end
            else
            begin
                pos_next = pos_inc;
                unique case (phase_reg)
                    PH_SKIP_START:
                    begin
                        if (pos_reg != '0)
                            phase_next = PH_EXPECT_FF;
                    end
                    PH_EXPECT_FF:
                    begin
                        if (data_byte != jsef_pkg::BYTE_FILL)
                        begin
                            if (!last_byte)
                            begin
                                has_res    = 1'b1;
                                res_status = jsef_pkg::STATUS_BROKEN;
                            end
                        end
                        else
                            phase_next = PH_MARKER;
                    end
                    PH_MARKER, PH_SCAN_FF:
                    begin
                        if (data_byte == jsef_pkg::BYTE_FILL)
                            phase_next = phase_reg;
                        else if (phase_reg == PH_SCAN_FF &&
                                 (data_byte == jsef_pkg::BYTE_STUFF || is_restart))
                            phase_next = PH_SCAN;
                        else if (data_byte == jsef_pkg::MARKER_EOI)
                        begin
                            has_res    = 1'b1;
                            res_status = jsef_pkg::STATUS_FOUND;
                            res_length = jsef_pkg::LenWidth'(pos_inc);
                        end
                        else if (is_restart)
                            phase_next = PH_EXPECT_FF;
                        else
                        begin
                            in_scan_next = (data_byte == jsef_pkg::MARKER_SOS);
                            phase_next   = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        seg_rem_next = {8'h00, data_byte};
                        phase_next   = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        if (seg_len < 16'd2)
                        begin
                            has_res    = 1'b1;
                            res_status = jsef_pkg::STATUS_BROKEN;
                        end
                        else
                        begin
                            seg_rem_next = seg_len - 16'd2;
                            if (seg_len == 16'd2)
                                phase_next = in_scan_reg ? PH_SCAN : PH_EXPECT_FF;
                            else
                                phase_next = PH_SKIP_BODY;
                        end
                    end
                    PH_SKIP_BODY:
                    begin
                        seg_rem_next = body_rem;
                        if (body_rem == 16'd0)
                            phase_next = in_scan_reg ? PH_SCAN : PH_EXPECT_FF;
                    end
                    PH_SCAN:
                    begin
                        if (data_byte == jsef_pkg::BYTE_FILL)
                            phase_next = PH_SCAN_FF;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            // stream ended without a decision
            if (!has_res && last_byte)
            begin
                has_res    = 1'b1;
                res_status = jsef_pkg::STATUS_RANOUT;
            end
        end

        if (has_res)
            decided_next = 1'b1;

        // rearm after the final byte
        if (last_byte)
        begin
            phase_next   = PH_SKIP_START;
            in_scan_next = 1'b0;
            seg_rem_next = '0;
            pos_next     = '0;
            decided_next = 1'b0;
        end
    end

    assign result.valid  = has_res;
    assign result.status = res_status;
    assign result.length = res_length;

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SKIP_START;
            in_scan_reg <= 1'b0;
            seg_rem_reg <= '0;
            pos_reg     <= '0;
            decided_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            in_scan_reg <= in_scan_next;
            seg_rem_reg <= seg_rem_next;
            pos_reg     <= pos_next;
            decided_reg <= decided_next;
        end
    end

endmodule

>>> src/jpeg_segment_end_finder_core.sv
// ----------------------------------------------------------------------------
// jpeg_segment_end_finder_core
// Finds the end of a jpeg image in a byte stream, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_ channel, one item per byte, starting with the 0xff
//   of the start marker; s_tlast marks the final available byte of a stream.
//   Each stream yields exactly one result item on the m_ channel: m_tuser is
//   the status (found, broken, ran out) and m_tdata the image length in bytes
//   through the end marker, zero unless found. After s_tlast the block
//   rearms for the next stream.
//   Output path: m_tvalid rises once the byte that decided it has passed the
//   input register and then the result register.
//   Throughput: one byte per cycle unless a waiting result stalls; the walker
//   decides each byte combinationally and the only loop is its registered state update.
//   Reset: clears the parse state and both stage valid flags; the first byte
//   after reset starts a new stream.
//   Stall: while m_tready is low and a result waits, the byte held in the
//   input register waits too and s_tready drops once it is occupied; no item
//   is lost or repeated.
// ----------------------------------------------------------------------------
module jpeg_segment_end_finder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] jpeg_length
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic                          in_vld_reg;
    logic [7:0]                    in_data_reg;
    logic                          in_last_reg;
    logic                          out_vld_reg;
    jsef_pkg::status_t             out_status_reg;
    logic [jsef_pkg::LenWidth-1:0] out_len_reg;
    logic                          advance;
    logic                          step;
    jsef_pkg::result_t             result;

    // pipeline moves when the result register is free or being emptied
    assign advance  = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    jsef_walker u_walker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .result    (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= step && result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= result.status;
            out_len_reg    <= result.length;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_len_reg;
    assign m_tuser  = out_status_reg;

endmodule

>>> dv/jsef_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jsef_checker
// Watches both streams of the jpeg segment end finder, walks every accepted
// byte through its own segment parser and compares each result item, status
// and length, against the oldest verdict it predicted.
// ----------------------------------------------------------------------------
module jsef_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] jpeg_length
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          fail_count,
    output int          pending_count
);

    // where the walker stands inside the stream
    typedef enum logic [2:0] {
        WALK_START   = 3'd0,
        WALK_FF      = 3'd1,
        WALK_CODE    = 3'd2,
        WALK_LEN_HI  = 3'd3,
        WALK_LEN_LO  = 3'd4,
        WALK_BODY    = 3'd5,
        WALK_SCAN    = 3'd6,
        WALK_SCAN_FF = 3'd7
    } walk_phase_t;

    typedef struct packed {
        jsef_pkg::status_t             status;
        logic [jsef_pkg::LenWidth-1:0] length;
    } verdict_t;

    walk_phase_t                   phase;
    logic                          in_scan;
    logic [15:0]                   seg_left;
    logic [jsef_pkg::PosWidth-1:0] byte_pos;
    logic                          decided;
    verdict_t                      verdict_q[$];

    task automatic clear_walk();
        phase    = WALK_START;
        in_scan  = 1'b0;
        seg_left = '0;
        byte_pos = '0;
        decided  = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        $display("%0t: mismatch on %s, expected %0h, got %0h", $time, what, want_v, got_v);
        fail_count++;
    endtask

    // a marker code byte: end of image, restart, or a length-prefixed segment
    task automatic take_marker(input logic [7:0] code,
                               input logic [jsef_pkg::PosWidth-1:0] pos,
                               inout logic hit, inout verdict_t v);
        if (code == jsef_pkg::MARKER_EOI)
        begin
            hit      = 1'b1;
            v.status = jsef_pkg::STATUS_FOUND;
            v.length = jsef_pkg::LenWidth'(pos + 1'b1);
        end
        else if (code >= jsef_pkg::MARKER_RST_LO && code <= jsef_pkg::MARKER_RST_HI)
        begin
            phase = WALK_FF;
        end
        else
        begin
            in_scan = (code == jsef_pkg::MARKER_SOS);
            phase   = WALK_LEN_HI;
        end
    endtask

    // advance the segment walk by one byte and queue any verdict it yields
    task automatic walk_byte(input logic [7:0] b, input logic lst);
        logic                          hit;
        verdict_t                      v;
        logic [15:0]                   seg_len;
        logic [jsef_pkg::PosWidth-1:0] pos;
        hit = 1'b0;
        v   = '{status: jsef_pkg::STATUS_FOUND, length: '0};
        if (!decided)
        begin
            if (byte_pos == '1)
            begin
                hit      = 1'b1;
                v.status = jsef_pkg::STATUS_RANOUT;
            end
            else
            begin
                pos      = byte_pos;
                byte_pos = pos + 1'b1;
                case (phase)
                    WALK_START:
                        if (pos >= 1) phase = WALK_FF;
                    WALK_FF:
                        if (b != jsef_pkg::BYTE_FILL)
                        begin
                            if (!lst)
                            begin
                                hit      = 1'b1;
                                v.status = jsef_pkg::STATUS_BROKEN;
                            end
                        end
                        else
                        begin
                            phase = WALK_CODE;
                        end
                    WALK_CODE:
                        if (b != jsef_pkg::BYTE_FILL) take_marker(b, pos, hit, v);
                    WALK_LEN_HI:
                    begin
                        seg_left = {8'h00, b};
                        phase    = WALK_LEN_LO;
                    end
                    WALK_LEN_LO:
                    begin
                        seg_len = {seg_left[7:0], b};
                        if (seg_len < 16'd2)
                        begin
                            hit      = 1'b1;
                            v.status = jsef_pkg::STATUS_BROKEN;
                        end
                        else
                        begin
                            seg_left = seg_len - 16'd2;
                            if (seg_left == 0) phase = in_scan ? WALK_SCAN : WALK_FF;
                            else phase = WALK_BODY;
                        end
                    end
                    WALK_BODY:
                    begin
                        if (seg_left > 0) seg_left = seg_left - 1'b1;
                        if (seg_left == 0) phase = in_scan ? WALK_SCAN : WALK_FF;
                    end
                    WALK_SCAN:
                        if (b == jsef_pkg::BYTE_FILL) phase = WALK_SCAN_FF;
                    default:
                        // stuffed zero and restart markers keep the scan going
                        if (b == jsef_pkg::BYTE_FILL)
                            phase = WALK_SCAN_FF;
                        else if (b == jsef_pkg::BYTE_STUFF ||
                                 (b >= jsef_pkg::MARKER_RST_LO &&
                                  b <= jsef_pkg::MARKER_RST_HI))
                            phase = WALK_SCAN;
                        else
                            take_marker(b, pos, hit, v);
                endcase
            end
            if (!hit && lst)
            begin
                hit      = 1'b1;
                v.status = jsef_pkg::STATUS_RANOUT;
            end
        end
        if (hit)
        begin
            verdict_q = {verdict_q, v};
            decided   = 1'b1;
        end
        if (lst) clear_walk();
    endtask

    // result side first: a result never comes from the byte taken at the same edge
    always @(posedge clk)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            clear_walk();
            verdict_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch("result with nothing expected", '0, {m_tuser, m_tdata[29:0]});
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", 32'(want.status), 32'(m_tuser));
                    if (m_tdata != want.length)
                        report_mismatch("jpeg_length", want.length, m_tdata);
                end
            end
            if (s_tvalid && s_tready) walk_byte(s_tdata, s_tlast);
        end
        pending_count = verdict_q.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives jpeg-like byte streams, directed corner cases first and then random
// well-formed, damaged, truncated and noise streams, into the segment end
// finder with random gaps and stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] jpeg_length
    logic [1:0]  m_tuser;   // [1:0] status
    int          fail_count;
    int          pending_count;

    logic [7:0]  stream_q[$];
    int          bytes_sent;

    jpeg_segment_end_finder_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    jsef_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL jpeg_segment_end_finder_core");
        $finish;
    end

    // result side: random stalls, one long hold-off, one stretch always ready
    initial
    begin
        int cyc;
        m_tready = 1'b0;
        cyc      = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc >= 800 && cyc < 1100)
                m_tready <= 1'b0;
            else if (cyc >= 1300 && cyc < 1600)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 26);
        end
    end

    // offer one byte, with random gaps outside the steady window
    task automatic send_byte(input logic [7:0] b, input logic lst);
        @(negedge clk);
        while (!(bytes_sent >= 500 && bytes_sent < 700) && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
    endtask

    // add one byte at the end of the stream under construction
    task automatic append_byte(input logic [7:0] b);
        stream_q = {stream_q, b};
    endtask

    // random stream: mostly well-formed segments with random content
    task automatic build_stream();
        int          r;
        int          seg_len;
        int          cut;
        logic [7:0]  code;
        stream_q.delete();
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
            return;
        end
        append_byte(jsef_pkg::BYTE_FILL);
        append_byte(($urandom_range(99) < 85) ? 8'hd8 : 8'($urandom));
        repeat ($urandom_range(0, 5))
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                // fill bytes ahead of the next marker
                repeat ($urandom_range(1, 3)) append_byte(jsef_pkg::BYTE_FILL);
            end
            else if (r < 20)
            begin
                append_byte(jsef_pkg::BYTE_FILL);
                append_byte(jsef_pkg::MARKER_RST_LO + 8'($urandom_range(7)));
            end
            else
            begin
                if ($urandom_range(99) < 30)
                    code = jsef_pkg::MARKER_SOS;
                else
                begin
                    code = 8'($urandom);
                    while (code == jsef_pkg::BYTE_FILL || code == jsef_pkg::MARKER_EOI
                           || (code >= jsef_pkg::MARKER_RST_LO &&
                               code <= jsef_pkg::MARKER_RST_HI))
                        code = 8'($urandom);
                end
                append_byte(jsef_pkg::BYTE_FILL);
                append_byte(code);
                r = $urandom_range(99);
                if (r < 3)
                    seg_len = $urandom_range(0, 1);
                else if (r < 6)
                    seg_len = $urandom_range(256, 600);
                else
                    seg_len = $urandom_range(2, 12);
                append_byte(8'(seg_len >> 8));
                append_byte(8'(seg_len));
                if (seg_len > 2)
                    repeat (seg_len - 2) append_byte(8'($urandom));
                // entropy-coded data with stuffing, restarts and fill
                if (code == jsef_pkg::MARKER_SOS)
                    repeat ($urandom_range(0, 12))
                    begin
                        r = $urandom_range(99);
                        if (r < 10)
                        begin
                            append_byte(jsef_pkg::BYTE_FILL);
                            append_byte(jsef_pkg::BYTE_STUFF);
                        end
                        else if (r < 16)
                        begin
                            append_byte(jsef_pkg::BYTE_FILL);
                            append_byte(jsef_pkg::MARKER_RST_LO + 8'($urandom_range(7)));
                        end
                        else if (r < 20)
                        begin
                            append_byte(jsef_pkg::BYTE_FILL);
                            append_byte(jsef_pkg::BYTE_FILL);
                            append_byte(jsef_pkg::BYTE_STUFF);
                        end
                        else
                            append_byte(8'($urandom_range(0, 254)));
                    end
            end
        end
        if ($urandom_range(99) < 90)
        begin
            append_byte(jsef_pkg::BYTE_FILL);
            append_byte(jsef_pkg::MARKER_EOI);
        end
        // damage, truncation and trailing bytes
        if ($urandom_range(99) < 10)
            stream_q[$urandom_range(stream_q.size() - 1)] = 8'($urandom);
        if ($urandom_range(99) < 12)
        begin
            cut = $urandom_range(1, stream_q.size());
            while (stream_q.size() > cut) void'(stream_q.pop_back());
        end
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        bytes_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // shortest image
        stream_q = '{8'hff, 8'hd8, 8'hff, 8'hd9};
        send_stream();
        // non-fill byte where a marker must start, then a silent last byte
        stream_q = '{8'hff, 8'hd8, 8'h41, 8'h00};
        send_stream();
        // marker code zero with a length below two
        stream_q = '{8'hff, 8'hd8, 8'hff, 8'h00, 8'h00, 8'h01};
        send_stream();
        // scan with stuffed zero, restart and fill ahead of the end marker
        stream_q = '{8'hff, 8'hd8, 8'hff, 8'hda, 8'h00, 8'h02, 8'hff, 8'h00,
                     8'hff, 8'hd0, 8'hff, 8'hff, 8'hd9};
        send_stream();

        while (bytes_sent < 1250)
        begin
            build_stream();
            send_stream();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS jpeg_segment_end_finder_core");
        else
            $display("FAIL jpeg_segment_end_finder_core");
        $finish;
    end

endmodule
